// ===== rtl/dmrw_pkg.sv =====
// ----------------------------------------------------------------------------
// dmrw_pkg
// Shared codes, limits and helper functions for the dual motor ramp
// controller with command and horn watchdogs.
// ----------------------------------------------------------------------------
package dmrw_pkg;

  // Item function codes.
  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_TARGET = 2'd1,
    FUNC_RELAY  = 2'd2,
    FUNC_STOP   = 2'd3
  } func_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_RAMP_STEP     = 2'd0,
    CFG_RAMP_INTERVAL = 2'd1,
    CFG_CMD_TIMEOUT   = 2'd2,
    CFG_HORN_TIMEOUT  = 2'd3
  } cfg_index_t;

  // Relay bit positions.
  localparam logic [1:0] HORN_BIT = 2'd0;

  // Direction codes.
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  // Speed limits and the duty snap threshold.
  localparam logic signed [7:0] SPEED_MAX = 8'sd100;
  localparam logic signed [7:0] SPEED_MIN = -8'sd100;
  localparam logic signed [7:0] SNAP_HI   = 8'sd75;
  localparam logic signed [7:0] SNAP_LO   = -8'sd75;
  localparam logic [6:0]        MAG_FULL  = 7'd100;

  // Reciprocal of 100 scaled by 2^22, rounded up; exact floor for x <= 25500.
  localparam int unsigned RECIP_SHIFT = 22;
  localparam logic [15:0] RECIP_100   = 16'd41944;

  // Configuration reset values.
  localparam logic [7:0]  RAMP_STEP_RST     = 8'd5;
  localparam logic [15:0] RAMP_INTERVAL_RST = 16'd100;
  localparam logic [15:0] CMD_TIMEOUT_RST   = 16'd1000;
  localparam logic [15:0] HORN_TIMEOUT_RST  = 16'd3000;

  // Saturate a requested speed to the legal range.
  function automatic logic signed [7:0] clamp_speed(input logic signed [7:0] v);
    logic signed [7:0] r;
    r = v;
    if (v > SPEED_MAX) r = SPEED_MAX;
    if (v < SPEED_MIN) r = SPEED_MIN;
    return r;
  endfunction

  // Move a current speed toward its target by step, never overshooting.
  function automatic logic signed [7:0] ramp_toward(input logic signed [7:0] cur,
                                                    input logic signed [7:0] tgt,
                                                    input logic [7:0]        step);
    logic signed [9:0] c;
    logic signed [9:0] t;
    logic signed [9:0] s;
    logic signed [9:0] n;
    c = {{2{cur[7]}}, cur};
    t = {{2{tgt[7]}}, tgt};
    s = {2'b00, step};
    n = c;
    if (c > t) begin
      n = c - s;
      if (n < t) n = t;
    end else if (c < t) begin
      n = c + s;
      if (n > t) n = t;
    end
    return n[7:0];
  endfunction

  // PWM duty: floor(m * 255 / 100), with magnitudes above 75 taken as full.
  function automatic logic [7:0] duty_of(input logic signed [7:0] v);
    logic [7:0]  a;
    logic [6:0]  m;
    logic [14:0] prod;
    logic [30:0] q;
    a = v[7] ? 8'(-v) : v;
    m = a[6:0];
    if (v > SNAP_HI || v < SNAP_LO) m = MAG_FULL;
    prod = {m, 8'b0} - {8'b0, m};
    q = 31'(prod) * 31'(RECIP_100);
    return q[RECIP_SHIFT +: 8];
  endfunction

  // Direction code from the sign of a speed.
  function automatic logic [1:0] dir_of(input logic signed [7:0] v);
    logic [1:0] d;
    d = DIR_STOP;
    if (v > 8'sd0) d = DIR_FWD;
    if (v < 8'sd0) d = DIR_REV;
    return d;
  endfunction

endpackage

// ===== rtl/dual_motor_ramp_watchdog.sv =====
// ----------------------------------------------------------------------------
// dual_motor_ramp_watchdog
// Pipeline: an accepted item is held in the input register, and its state
// update writes its result beat into the result register.
// Throughput: one item per cycle while out_stall is low; result and input
// registers form a two-deep pipeline, so input stalls only when both are full.
// Reset: synchronous; clears time, stamps, speeds, relays and the valid flags,
// and restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module dual_motor_ramp_watchdog (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  // Input channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             func,
  input  logic                   motor_select,
  input  logic signed [7:0]      speed_value,
  input  logic [1:0]             relay_select,
  input  logic                   relay_on,
  // Result channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             left_duty,
  output logic [1:0]             left_dir,
  output logic [7:0]             right_duty,
  output logic [1:0]             right_dir,
  output logic signed [7:0]      left_speed,
  output logic signed [7:0]      right_speed,
  output logic signed [7:0]      left_target,
  output logic signed [7:0]      right_target,
  output logic                   horn_on,
  output logic                   lights_on,
  output logic                   strobe_on,
  output logic                   hitch_on
);
  import dmrw_pkg::*;

  // Configuration registers.
  logic [7:0]  ramp_step;
  logic [15:0] ramp_interval_ms;
  logic [15:0] command_timeout_ms;
  logic [15:0] horn_timeout_ms;

  // Input register.
  logic              s1_valid;
  func_t             s1_func;
  logic              s1_motor;
  logic signed [7:0] s1_speed;
  logic [1:0]        s1_relay;
  logic              s1_relay_on;

  // Block state.
  logic [31:0]       time_now;
  logic [31:0]       left_cmd_time;
  logic [31:0]       right_cmd_time;
  logic [31:0]       horn_on_time;
  logic [31:0]       last_ramp_time;
  logic signed [7:0] left_tgt;
  logic signed [7:0] right_tgt;
  logic signed [7:0] left_cur;
  logic signed [7:0] right_cur;
  logic [3:0]        relay_states;

  // Next state.
  logic [31:0]       time_now_next;
  logic [31:0]       left_cmd_time_next;
  logic [31:0]       right_cmd_time_next;
  logic [31:0]       horn_on_time_next;
  logic [31:0]       last_ramp_time_next;
  logic signed [7:0] left_tgt_next;
  logic signed [7:0] right_tgt_next;
  logic signed [7:0] left_cur_next;
  logic signed [7:0] right_cur_next;
  logic [3:0]        relay_states_next;

  logic              s1_adv;
  logic              in_take;
  logic [31:0]       time_inc;
  logic [31:0]       left_age;
  logic [31:0]       right_age;
  logic [31:0]       horn_age;
  logic [31:0]       ramp_age;

  // Pipeline handshake: the input register moves on whenever the result
  // register is empty or its beat is being taken.
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_step          <= RAMP_STEP_RST;
      ramp_interval_ms   <= RAMP_INTERVAL_RST;
      command_timeout_ms <= CMD_TIMEOUT_RST;
      horn_timeout_ms    <= HORN_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_RAMP_STEP:     ramp_step          <= cfg_data[7:0];
        CFG_RAMP_INTERVAL: ramp_interval_ms   <= cfg_data;
        CFG_CMD_TIMEOUT:   command_timeout_ms <= cfg_data;
        CFG_HORN_TIMEOUT:  horn_timeout_ms    <= cfg_data;
        default:           ramp_step          <= ramp_step;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func     <= func_t'(func);
      s1_motor    <= motor_select;
      s1_speed    <= speed_value;
      s1_relay    <= relay_select;
      s1_relay_on <= relay_on;
    end
  end

  // Elapsed times against the advanced clock, modulo 2^32.
  assign time_inc  = time_now + 32'd1;
  assign left_age  = time_inc - left_cmd_time;
  assign right_age = time_inc - right_cmd_time;
  assign horn_age  = time_inc - horn_on_time;
  assign ramp_age  = time_inc - last_ramp_time;

  // State update for the item held in the input register.
  always_comb begin
    time_now_next       = time_now;
    left_cmd_time_next  = left_cmd_time;
    right_cmd_time_next = right_cmd_time;
    horn_on_time_next   = horn_on_time;
    last_ramp_time_next = last_ramp_time;
    left_tgt_next       = left_tgt;
    right_tgt_next      = right_tgt;
    left_cur_next       = left_cur;
    right_cur_next      = right_cur;
    relay_states_next   = relay_states;
    unique case (s1_func)
      FUNC_TICK: begin
        time_now_next = time_inc;
        // Command watchdog: a stale nonzero target drops to zero.
        if (left_tgt != 8'sd0 && left_age > {16'b0, command_timeout_ms}) begin
          left_tgt_next = 8'sd0;
        end
        if (right_tgt != 8'sd0 && right_age > {16'b0, command_timeout_ms}) begin
          right_tgt_next = 8'sd0;
        end
        // Horn watchdog.
        if (relay_states[HORN_BIT] && horn_age > {16'b0, horn_timeout_ms}) begin
          relay_states_next[HORN_BIT] = 1'b0;
        end
        // Ramp update toward the targets as they stand after the watchdog.
        if (ramp_age > {16'b0, ramp_interval_ms}) begin
          left_cur_next       = ramp_toward(left_cur, left_tgt_next, ramp_step);
          right_cur_next      = ramp_toward(right_cur, right_tgt_next, ramp_step);
          last_ramp_time_next = time_inc;
        end
      end
      FUNC_TARGET: begin
        if (s1_motor) begin
          right_tgt_next      = clamp_speed(s1_speed);
          right_cmd_time_next = time_now;
        end else begin
          left_tgt_next      = clamp_speed(s1_speed);
          left_cmd_time_next = time_now;
        end
      end
      FUNC_RELAY: begin
        relay_states_next[s1_relay] = s1_relay_on;
        // Every horn on command restarts its timer.
        if (s1_relay_on && s1_relay == HORN_BIT) begin
          horn_on_time_next = time_now;
        end
      end
      FUNC_STOP: begin
        left_cur_next  = 8'sd0;
        right_cur_next = 8'sd0;
      end
      default: begin
        time_now_next = time_now;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now       <= '0;
      left_cmd_time  <= '0;
      right_cmd_time <= '0;
      horn_on_time   <= '0;
      last_ramp_time <= '0;
      left_tgt       <= '0;
      right_tgt      <= '0;
      left_cur       <= '0;
      right_cur      <= '0;
      relay_states   <= '0;
    end else if (s1_adv) begin
      time_now       <= time_now_next;
      left_cmd_time  <= left_cmd_time_next;
      right_cmd_time <= right_cmd_time_next;
      horn_on_time   <= horn_on_time_next;
      last_ramp_time <= last_ramp_time_next;
      left_tgt       <= left_tgt_next;
      right_tgt      <= right_tgt_next;
      left_cur       <= left_cur_next;
      right_cur      <= right_cur_next;
      relay_states   <= relay_states_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, taken from the updated state.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      left_duty    <= duty_of(left_cur_next);
      left_dir     <= dir_of(left_cur_next);
      right_duty   <= duty_of(right_cur_next);
      right_dir    <= dir_of(right_cur_next);
      left_speed   <= left_cur_next;
      right_speed  <= right_cur_next;
      left_target  <= left_tgt_next;
      right_target <= right_tgt_next;
      horn_on      <= relay_states_next[0];
      lights_on    <= relay_states_next[1];
      strobe_on    <= relay_states_next[2];
      hitch_on     <= relay_states_next[3];
    end
  end

`ifndef SYNTHESIS
  // The input side only stalls while the input register holds an item.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty input register");

  // A stopped left motor shows no duty and no direction.
  a_left_stopped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && left_speed == 8'sd0) |-> (left_duty == 8'd0 && left_dir == DIR_STOP))
    else $error("left motor stopped but duty or direction set");

  // Ramped speeds stay within the legal range.
  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (left_cur <= SPEED_MAX && left_cur >= SPEED_MIN &&
                right_cur <= SPEED_MAX && right_cur >= SPEED_MIN))
    else $error("current speed out of range");

  // Only a tick advances the millisecond counter; this checks that it steps by exactly one.
  a_time_step: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_func == FUNC_TICK) |=> (time_now == $past(time_now) + 32'd1))
    else $error("tick did not advance time by one");
`endif

endmodule

// ===== sim/dmrw_checker.sv =====
// ----------------------------------------------------------------------------
// dmrw_checker
// Watches the configuration port and both channels of the dual motor ramp
// controller. It keeps its own copy of the motor, timer and relay state,
// works out the status beat that each accepted item should produce, and
// compares every result beat with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module dmrw_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        func,
  input  logic              motor_select,
  input  logic signed [7:0] speed_value,
  input  logic [1:0]        relay_select,
  input  logic              relay_on,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [7:0]        left_duty,
  input  logic [1:0]        left_dir,
  input  logic [7:0]        right_duty,
  input  logic [1:0]        right_dir,
  input  logic signed [7:0] left_speed,
  input  logic signed [7:0] right_speed,
  input  logic signed [7:0] left_target,
  input  logic signed [7:0] right_target,
  input  logic              horn_on,
  input  logic              lights_on,
  input  logic              strobe_on,
  input  logic              hitch_on,
  output int                mismatches,
  output int                outstanding,
  output int                compared
);
  timeunit 1ns;
  timeprecision 1ps;
  import dmrw_pkg::*;

  // One predicted status beat; relay bits are {hitch, strobe, lights, horn}.
  typedef struct packed {
    logic [7:0]        l_duty;
    logic [1:0]        l_dir;
    logic [7:0]        r_duty;
    logic [1:0]        r_dir;
    logic signed [7:0] l_spd;
    logic signed [7:0] r_spd;
    logic signed [7:0] l_tgt;
    logic signed [7:0] r_tgt;
    logic [3:0]        relays;
  } drive_status_t;

  // Shadow of the register file.
  logic [7:0]  step_cfg;
  logic [15:0] interval_cfg;
  logic [15:0] cmd_limit_cfg;
  logic [15:0] horn_limit_cfg;

  // Shadow of the controller state.
  logic [31:0]       now_ms;
  logic [31:0]       left_stamp;
  logic [31:0]       right_stamp;
  logic [31:0]       horn_stamp;
  logic [31:0]       ramp_stamp;
  logic signed [7:0] tgt [2];
  logic signed [7:0] cur [2];
  logic [3:0]        relays;

  drive_status_t status_q [$];
  int            err_cnt  = 0;
  int            beat_cnt = 0;

  // Step a speed toward its target without overshooting it.
  function automatic logic signed [7:0] slew(input logic signed [7:0] c,
                                            input logic signed [7:0] t);
    int n;
    n = c;
    if (c > t) begin
      n = int'(c) - int'(step_cfg);
      if (n < t) n = t;
    end else if (c < t) begin
      n = int'(c) + int'(step_cfg);
      if (n > t) n = t;
    end
    return 8'(n);
  endfunction

  // Duty from magnitude; anything beyond 75 either way counts as full speed.
  function automatic logic [7:0] duty_for(input logic signed [7:0] v);
    int m;
    m = v;
    if (m > 75) m = 100;
    if (m < -75) m = -100;
    if (m < 0) m = -m;
    return 8'(m * 255 / 100);
  endfunction

  function automatic logic [1:0] dir_for(input logic signed [7:0] v);
    if (v > 0) return DIR_FWD;
    if (v < 0) return DIR_REV;
    return DIR_STOP;
  endfunction

  // One millisecond: command watchdog, horn watchdog, then the ramp.
  function automatic void advance_ms();
    now_ms = now_ms + 32'd1;
    if (tgt[1] != 0 && (now_ms - right_stamp) > {16'd0, cmd_limit_cfg}) tgt[1] = '0;
    if (tgt[0] != 0 && (now_ms - left_stamp) > {16'd0, cmd_limit_cfg}) tgt[0] = '0;
    if (relays[HORN_BIT] && (now_ms - horn_stamp) > {16'd0, horn_limit_cfg})
      relays[HORN_BIT] = 1'b0;
    if ((now_ms - ramp_stamp) > {16'd0, interval_cfg}) begin
      cur[0]     = slew(cur[0], tgt[0]);
      cur[1]     = slew(cur[1], tgt[1]);
      ramp_stamp = now_ms;
    end
  endfunction

  // Apply one accepted item to the shadow state and return the status beat.
  function automatic drive_status_t predict_beat(input logic [1:0] f,
                                                 input logic sel,
                                                 input logic signed [7:0] spd,
                                                 input logic [1:0] rsel,
                                                 input logic ron);
    drive_status_t s;
    int            v;
    case (func_t'(f))
      FUNC_TICK: advance_ms();
      FUNC_TARGET: begin
        v = spd;
        if (v > 100) v = 100;
        if (v < -100) v = -100;
        tgt[sel] = 8'(v);
        if (sel) right_stamp = now_ms;
        else left_stamp = now_ms;
      end
      FUNC_RELAY: begin
        relays[rsel] = ron;
        // Every on command for the horn restarts its timer.
        if (ron && rsel == HORN_BIT) horn_stamp = now_ms;
      end
      default: begin
        cur[0] = '0;
        cur[1] = '0;
      end
    endcase
    s.l_duty = duty_for(cur[0]);
    s.l_dir  = dir_for(cur[0]);
    s.r_duty = duty_for(cur[1]);
    s.r_dir  = dir_for(cur[1]);
    s.l_spd  = cur[0];
    s.r_spd  = cur[1];
    s.l_tgt  = tgt[0];
    s.r_tgt  = tgt[1];
    s.relays = relays;
    return s;
  endfunction

  // Returns 1 when a field differs; the first reports carry both values.
  function automatic int field_miss(input string name, input logic signed [8:0] want,
                                    input logic signed [8:0] got);
    if (got === want) return 0;
    if (err_cnt < 10)
      $display("[%0t] beat %0d %s: expected %0d, got %0d", $time, beat_cnt, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    drive_status_t want;
    int            bad;
    if (rst) begin
      step_cfg       = RAMP_STEP_RST;
      interval_cfg   = RAMP_INTERVAL_RST;
      cmd_limit_cfg  = CMD_TIMEOUT_RST;
      horn_limit_cfg = HORN_TIMEOUT_RST;
      now_ms         = '0;
      left_stamp     = '0;
      right_stamp    = '0;
      horn_stamp     = '0;
      ramp_stamp     = '0;
      tgt            = '{default: '0};
      cur            = '{default: '0};
      relays         = '0;
      status_q.delete();
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_RAMP_STEP:     step_cfg       = cfg_data[7:0];
          CFG_RAMP_INTERVAL: interval_cfg   = cfg_data;
          CFG_CMD_TIMEOUT:   cmd_limit_cfg  = cfg_data;
          CFG_HORN_TIMEOUT:  horn_limit_cfg = cfg_data;
          default: ;
        endcase
      end

      // Result beats are checked against the oldest prediction.
      if (out_valid && !out_stall) begin
        beat_cnt++;
        if (status_q.size() == 0) begin
          if (err_cnt < 10) $display("[%0t] result beat %0d with nothing expected", $time,
                                     beat_cnt);
          err_cnt++;
        end else begin
          want = status_q.pop_front();
          bad  = 0;
          bad += field_miss("left_duty", want.l_duty, left_duty);
          bad += field_miss("left_dir", want.l_dir, left_dir);
          bad += field_miss("right_duty", want.r_duty, right_duty);
          bad += field_miss("right_dir", want.r_dir, right_dir);
          bad += field_miss("left_speed", want.l_spd, left_speed);
          bad += field_miss("right_speed", want.r_spd, right_speed);
          bad += field_miss("left_target", want.l_tgt, left_target);
          bad += field_miss("right_target", want.r_tgt, right_target);
          bad += field_miss("horn_on", want.relays[0], horn_on);
          bad += field_miss("lights_on", want.relays[1], lights_on);
          bad += field_miss("strobe_on", want.relays[2], strobe_on);
          bad += field_miss("hitch_on", want.relays[3], hitch_on);
          if (bad != 0) err_cnt++;
        end
      end

      // Input beats update the shadow state.
      if (in_valid && !in_stall)
        status_q.push_back(predict_beat(func, motor_select, speed_value, relay_select,
                                        relay_on));
    end
    mismatches  <= err_cnt;
    outstanding <= status_q.size();
    compared    <= beat_cnt;
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the dual motor ramp controller. A directed run
// through clamping, timeouts, relays and all-stop is followed by random
// item streams under several register settings and idling patterns; the
// checker beside the block predicts and compares every status beat.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dmrw_pkg::*;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              cfg_we       = 1'b0;
  logic [1:0]        cfg_index    = '0;
  logic [15:0]       cfg_data     = '0;
  logic              in_valid     = 1'b0;
  logic [1:0]        func         = '0;
  logic              motor_select = 1'b0;
  logic signed [7:0] speed_value  = '0;
  logic [1:0]        relay_select = '0;
  logic              relay_on     = 1'b0;
  logic              out_stall    = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [7:0]        left_duty;
  logic [1:0]        left_dir;
  logic [7:0]        right_duty;
  logic [1:0]        right_dir;
  logic signed [7:0] left_speed;
  logic signed [7:0] right_speed;
  logic signed [7:0] left_target;
  logic signed [7:0] right_target;
  logic              horn_on;
  logic              lights_on;
  logic              strobe_on;
  logic              hitch_on;
  int                mismatches;
  int                outstanding;
  int                compared;

  int idle_pct  = 0;
  int stall_pct = 0;
  int sent      = 0;
  int kind_sent [4] = '{default: 0};

  dual_motor_ramp_watchdog dut (.*);
  dmrw_checker status_check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver back-pressure for the current phase.
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Hold the sender off until every predicted beat has been returned.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write all four registers once the block has gone quiet.
  task automatic load_settings(input logic [7:0] step, input logic [15:0] interval,
                               input logic [15:0] cmd_limit, input logic [15:0] horn_limit);
    drain();
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RAMP_STEP;
    cfg_data <= {8'd0, step};
    @(posedge clk);
    cfg_index <= CFG_RAMP_INTERVAL;
    cfg_data <= interval;
    @(posedge clk);
    cfg_index <= CFG_CMD_TIMEOUT;
    cfg_data <= cmd_limit;
    @(posedge clk);
    cfg_index <= CFG_HORN_TIMEOUT;
    cfg_data <= horn_limit;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Present one input beat, with random sender gaps, and wait for acceptance.
  task automatic send_beat(input func_t f, input logic sel, input logic signed [7:0] spd,
                           input logic [1:0] rsel, input logic ron);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    motor_select <= sel;
    speed_value  <= spd;
    relay_select <= rsel;
    relay_on     <= ron;
    do @(posedge clk); while (in_stall);
    sent++;
    kind_sent[f]++;
  endtask

  // Item kinds; the fields an item does not use carry noise.
  task automatic tick_beat();
    send_beat(FUNC_TICK, 1'($urandom), 8'($urandom), 2'($urandom), 1'($urandom));
  endtask

  task automatic target_beat(input logic sel, input logic signed [7:0] spd);
    send_beat(FUNC_TARGET, sel, spd, 2'($urandom), 1'($urandom));
  endtask

  task automatic relay_beat(input logic [1:0] rsel, input logic ron);
    send_beat(FUNC_RELAY, 1'($urandom), 8'($urandom), rsel, ron);
  endtask

  task automatic stop_beat();
    send_beat(FUNC_STOP, 1'($urandom), 8'($urandom), 2'($urandom), 1'($urandom));
  endtask

  // Random traffic: mostly ticks, with tick bursts so that watchdogs expire.
  task automatic send_random();
    int                roll;
    logic signed [7:0] spd;
    roll = $urandom_range(99);
    if (roll < 8) begin
      repeat ($urandom_range(40, 5)) tick_beat();
    end else if (roll < 55) begin
      tick_beat();
    end else if (roll < 75) begin
      if ($urandom_range(4) == 0) spd = 8'($urandom);
      else spd = 8'(int'($urandom_range(200)) - 100);
      target_beat(1'($urandom), spd);
    end else if (roll < 91) begin
      relay_beat(2'($urandom), ($urandom_range(9) < 7));
    end else begin
      stop_beat();
    end
  endtask

  initial begin
    int phase_start;
    int idle_tab  [5] = '{0, 46, 0, 32, 0};
    int stall_tab [5] = '{0, 0, 46, 32, 0};
    logic [7:0]  step_tab  [5] = '{8'd7, 8'd1, 8'd0, 8'd200, 8'd25};
    logic [15:0] ival_tab  [5] = '{16'd3, 16'd0, 16'd1, 16'hFFFF, 16'd2};
    logic [15:0] cmd_tab   [5] = '{16'd20, 16'd0, 16'hFFFF, 16'd5, 16'd40};
    logic [15:0] horn_tab  [5] = '{16'd15, 16'd0, 16'hFFFF, 16'd4, 16'd30};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: full step, no ramp delay, very short watchdogs.
    load_settings(8'd200, 16'd0, 16'd2, 16'd1);
    target_beat(1'b0, 8'sd127);
    target_beat(1'b1, -8'sd128);
    tick_beat();
    relay_beat(2'd0, 1'b1);
    relay_beat(2'd1, 1'b1);
    relay_beat(2'd2, 1'b1);
    relay_beat(2'd3, 1'b1);
    tick_beat();
    // A second horn-on restarts its timer, so the next tick keeps it on.
    relay_beat(2'd0, 1'b1);
    tick_beat();
    target_beat(1'b0, 8'sd101);
    target_beat(1'b1, -8'sd101);
    stop_beat();
    tick_beat();
    target_beat(1'b0, 8'sd76);
    target_beat(1'b1, -8'sd76);
    tick_beat();
    target_beat(1'b0, 8'sd75);
    target_beat(1'b1, -8'sd75);
    tick_beat();
    relay_beat(2'd0, 1'b0);
    relay_beat(2'd3, 1'b0);
    target_beat(1'b0, 8'sd1);
    target_beat(1'b1, -8'sd1);
    tick_beat();

    // Random phases, each with its own settings and an idle and stall mix from the tables.
    for (int p = 0; p < 5; p++) begin
      load_settings(step_tab[p], ival_tab[p], cmd_tab[p], horn_tab[p]);
      idle_pct    = idle_tab[p];
      stall_pct   = stall_tab[p];
      phase_start = sent;
      while (sent - phase_start < 47) send_random();
      drain();
      while (sent - phase_start < 95) send_random();
    end

    drain();
    idle_pct  = 0;
    stall_pct = 0;
    repeat (10) @(posedge clk);

    $display("Sent %0d items: %0d ticks, %0d target, %0d relay, %0d all-stop commands.",
             sent, kind_sent[FUNC_TICK], kind_sent[FUNC_TARGET], kind_sent[FUNC_RELAY],
             kind_sent[FUNC_STOP]);
    $display("Six register settings; %0d status beats compared, %0d with errors.",
             compared, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #2000000;
    $display("Timed out with %0d beats still expected.", outstanding);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dmrw_pkg.sv
rtl/dual_motor_ramp_watchdog.sv
sim/dmrw_checker.sv
sim/tb_top.sv
